// ----- hw/rtl/i2cm_pkg.sv -----
// Shared types, codes and constants for the I2C register-access master.
package i2cm_pkg;

    // Largest number of data bytes in one transfer (payload buffer depth)
    localparam int unsigned MAX_BYTES = 16;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int unsigned SLOT_W    = $clog2(MAX_BYTES);

    // Reset values of the configuration registers
    localparam logic [15:0] PHASE_TICKS_RST = 16'd200;
    localparam logic [9:0]  ACK_POLL_RST    = 10'd251;

    // Configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_POLL    = 1'b1;

    // Opcodes of an input item
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_LOAD  = 2'd3;

    // Byte stage: which header byte is on the bus, or the data bytes after them
    localparam logic [1:0] STG_ADDR  = 2'd0;
    localparam logic [1:0] STG_REG   = 2'd1;
    localparam logic [1:0] STG_RADDR = 2'd2;
    localparam logic [1:0] STG_DATA  = 2'd3;

    // Bus phases
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_STA_A  = 5'd1,
        PH_STA_B  = 5'd2,
        PH_W_LOW  = 5'd3,
        PH_W_HIGH = 5'd4,
        PH_W_TAIL = 5'd5,
        PH_A_LOW  = 5'd6,
        PH_A_HIGH = 5'd7,
        PH_A_POLL = 5'd8,
        PH_A_TAIL = 5'd9,
        PH_R_H1   = 5'd10,
        PH_R_H2   = 5'd11,
        PH_R_LOW  = 5'd12,
        PH_K_SET  = 5'd13,
        PH_K_HIGH = 5'd14,
        PH_K_LOW  = 5'd15,
        PH_STO_A  = 5'd16,
        PH_STO_B  = 5'd17
    } t_phase;

    // One input item (one bus tick)
    typedef struct packed {
        logic [1:0]       opcode;
        logic [6:0]       device_address;
        logic [7:0]       register_address;
        logic [CNT_W-1:0] byte_count;
        logic [3:0]       payload_index;
        logic [7:0]       payload_byte;
        logic             sda_sample;
    } t_in;

    // One result item (pin levels and status after the tick)
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       transfer_done;
        logic       ack_error;
        logic       busy_res;
    } t_out;

endpackage

// ----- hw/rtl/i2cm_payload.sv -----
// Write payload buffer: register file with write-to-read forwarding.
module i2cm_payload (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [i2cm_pkg::SLOT_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic [i2cm_pkg::SLOT_W-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);

    logic [7:0] r_mem [i2cm_pkg::MAX_BYTES];

    // Store a loaded byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A byte loaded on the same tick is seen by that tick's read
    assign o_rdata = (i_we && (i_waddr == i_raddr)) ? i_wdata : r_mem[i_raddr];

endmodule

// ----- hw/rtl/i2cm_core.sv -----
// Bus sequencer: advances the I2C master by one tick per processed item.
module i2cm_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  i2cm_pkg::t_in               i_item,
    input  logic [15:0]                 i_phase_ticks,
    input  logic [9:0]                  i_ack_poll_limit,
    input  logic [7:0]                  i_pay_rdata,
    output logic [i2cm_pkg::SLOT_W-1:0] o_pay_raddr,
    output i2cm_pkg::t_out              o_result
);

    localparam int unsigned CW = i2cm_pkg::CNT_W;

    i2cm_pkg::t_phase r_phase, n_phase;
    logic [15:0]   r_dc, n_dc;
    logic [3:0]    r_bc, n_bc;
    logic [7:0]    r_shift, n_shift;
    logic [CW-1:0] r_bd, n_bd;
    logic [9:0]    r_poll, n_poll;
    logic          r_err, n_err;
    logic [6:0]    r_dev, n_dev;
    logic [7:0]    r_reg, n_reg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_rd, n_rd;
    logic [1:0]    r_stage, n_stage;

    logic [15:0]   w_dc_inc;
    logic          w_delay_done;
    logic [3:0]    w_bc_inc;
    logic [CW-1:0] w_bd_inc;
    logic [CW-1:0] w_cnt_sat;
    logic          w_rvalid;
    logic [7:0]    w_rdata;
    logic          w_rlast;
    logic          w_done;
    logic          w_bitpull;
    logic          w_ackpull;
    logic          w_scl;
    logic          w_pull;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cm_pkg::PH_IDLE;
            r_dc    <= '0;
            r_bc    <= '0;
            r_shift <= '0;
            r_bd    <= '0;
            r_poll  <= '0;
            r_err   <= 1'b0;
            r_dev   <= '0;
            r_reg   <= '0;
            r_cnt   <= '0;
            r_rd    <= 1'b0;
            r_stage <= i2cm_pkg::STG_ADDR;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_bc    <= n_bc;
            r_shift <= n_shift;
            r_bd    <= n_bd;
            r_poll  <= n_poll;
            r_err   <= n_err;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_stage <= n_stage;
        end
    end

    // Shared increments; a zero phase_ticks acts as one tick
    assign w_dc_inc     = r_dc + 16'd1;
    assign w_delay_done = (w_dc_inc >= i_phase_ticks);
    assign w_bc_inc     = r_bc + 4'd1;
    assign w_bd_inc     = r_bd + CW'(1);
    assign w_cnt_sat    = (i_item.byte_count > CW'(i2cm_pkg::MAX_BYTES))
                          ? CW'(i2cm_pkg::MAX_BYTES) : i_item.byte_count;

    // Payload slot for the next write data byte
    assign o_pay_raddr = (r_stage == i2cm_pkg::STG_REG)
                         ? r_bd[i2cm_pkg::SLOT_W-1:0] : w_bd_inc[i2cm_pkg::SLOT_W-1:0];

    // Next state of the sequencer
    always_comb begin
        n_phase  = r_phase;
        n_dc     = r_dc;
        n_bc     = r_bc;
        n_shift  = r_shift;
        n_bd     = r_bd;
        n_poll   = r_poll;
        n_err    = r_err;
        n_dev    = r_dev;
        n_reg    = r_reg;
        n_cnt    = r_cnt;
        n_rd     = r_rd;
        n_stage  = r_stage;
        w_rvalid = 1'b0;
        w_rdata  = 8'd0;
        w_rlast  = 1'b0;
        w_done   = 1'b0;

        case (r_phase)
            i2cm_pkg::PH_IDLE: begin
                if (i_item.opcode == i2cm_pkg::OP_READ ||
                    i_item.opcode == i2cm_pkg::OP_WRITE) begin
                    n_rd    = (i_item.opcode == i2cm_pkg::OP_READ);
                    n_cnt   = (n_rd && w_cnt_sat == '0) ? CW'(1) : w_cnt_sat;
                    n_dev   = i_item.device_address;
                    n_reg   = i_item.register_address;
                    n_bd    = '0;
                    n_err   = 1'b0;
                    n_stage = i2cm_pkg::STG_ADDR;
                    n_phase = i2cm_pkg::PH_STA_A;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_STA_A: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_STA_B;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_STA_B: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_shift = {r_dev, (r_stage == i2cm_pkg::STG_RADDR)};
                    n_bc    = '0;
                    n_phase = i2cm_pkg::PH_W_LOW;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_W_LOW: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_W_HIGH;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_W_HIGH: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_W_TAIL;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_W_TAIL: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_bc    = w_bc_inc;
                    n_shift = {r_shift[6:0], 1'b0};
                    n_phase = (w_bc_inc >= 4'd8) ? i2cm_pkg::PH_A_LOW : i2cm_pkg::PH_W_LOW;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_A_LOW: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_A_HIGH;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_A_HIGH: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_poll  = '0;
                    n_phase = i2cm_pkg::PH_A_POLL;
                    n_dc    = '0;
                end
            end
            // Wait for the slave to pull SDA low, bounded by ack_poll_limit
            i2cm_pkg::PH_A_POLL: begin
                if (!i_item.sda_sample) begin
                    n_phase = i2cm_pkg::PH_A_TAIL;
                    n_dc    = '0;
                end else if (r_poll >= i_ack_poll_limit) begin
                    n_err   = 1'b1;
                    n_phase = i2cm_pkg::PH_A_TAIL;
                    n_dc    = '0;
                end else begin
                    n_poll = r_poll + 10'd1;
                end
            end
            // After the acknowledge: pick the next byte or the STOP
            i2cm_pkg::PH_A_TAIL: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_dc = '0;
                    case (r_stage)
                        i2cm_pkg::STG_ADDR: begin
                            n_stage = i2cm_pkg::STG_REG;
                            n_shift = r_reg;
                            n_bc    = '0;
                            n_phase = i2cm_pkg::PH_W_LOW;
                        end
                        i2cm_pkg::STG_REG: begin
                            if (r_rd) begin
                                n_stage = i2cm_pkg::STG_RADDR;
                                n_phase = i2cm_pkg::PH_STA_A;
                            end else if (r_bd < r_cnt) begin
                                n_stage = i2cm_pkg::STG_DATA;
                                n_shift = i_pay_rdata;
                                n_bc    = '0;
                                n_phase = i2cm_pkg::PH_W_LOW;
                            end else begin
                                n_phase = i2cm_pkg::PH_STO_A;
                            end
                        end
                        i2cm_pkg::STG_RADDR: begin
                            n_stage = i2cm_pkg::STG_DATA;
                            n_shift = '0;
                            n_bc    = '0;
                            n_phase = i2cm_pkg::PH_R_H1;
                        end
                        default: begin
                            n_bd = w_bd_inc;
                            if (w_bd_inc < r_cnt) begin
                                n_shift = i_pay_rdata;
                                n_bc    = '0;
                                n_phase = i2cm_pkg::PH_W_LOW;
                            end else begin
                                n_phase = i2cm_pkg::PH_STO_A;
                            end
                        end
                    endcase
                end
            end
            // Read bit: sample SDA at the end of the first high step
            i2cm_pkg::PH_R_H1: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_shift = {r_shift[6:0], i_item.sda_sample};
                    n_phase = i2cm_pkg::PH_R_H2;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_R_H2: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_R_LOW;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_R_LOW: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_bc = w_bc_inc;
                    n_dc = '0;
                    if (w_bc_inc >= 4'd8) begin
                        w_rvalid = 1'b1;
                        w_rdata  = r_shift;
                        w_rlast  = ({1'b0, r_bd} + (CW+1)'(1)) >= {1'b0, r_cnt};
                        n_phase  = i2cm_pkg::PH_K_SET;
                    end else begin
                        n_phase = i2cm_pkg::PH_R_H1;
                    end
                end
            end
            i2cm_pkg::PH_K_SET: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_K_HIGH;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_K_HIGH: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_K_LOW;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_K_LOW: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_bd = w_bd_inc;
                    n_dc = '0;
                    if (w_bd_inc < r_cnt) begin
                        n_shift = '0;
                        n_bc    = '0;
                        n_phase = i2cm_pkg::PH_R_H1;
                    end else begin
                        n_phase = i2cm_pkg::PH_STO_A;
                    end
                end
            end
            i2cm_pkg::PH_STO_A: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    n_phase = i2cm_pkg::PH_STO_B;
                    n_dc    = '0;
                end
            end
            i2cm_pkg::PH_STO_B: begin
                n_dc = w_dc_inc;
                if (w_delay_done) begin
                    w_done  = 1'b1;
                    n_phase = i2cm_pkg::PH_IDLE;
                    n_dc    = '0;
                end
            end
            default: begin
                n_phase = i2cm_pkg::PH_IDLE;
                n_dc    = '0;
            end
        endcase
    end

    // Pin levels after the tick
    assign w_bitpull = ~n_shift[7];
    assign w_ackpull = ~(({1'b0, n_bd} + (CW+1)'(1)) >= {1'b0, n_cnt});

    always_comb begin
        case (n_phase)
            i2cm_pkg::PH_STA_A:  begin w_scl = 1'b1; w_pull = 1'b0;      end
            i2cm_pkg::PH_STA_B:  begin w_scl = 1'b1; w_pull = 1'b1;      end
            i2cm_pkg::PH_W_LOW,
            i2cm_pkg::PH_W_TAIL: begin w_scl = 1'b0; w_pull = w_bitpull; end
            i2cm_pkg::PH_W_HIGH: begin w_scl = 1'b1; w_pull = w_bitpull; end
            i2cm_pkg::PH_A_LOW,
            i2cm_pkg::PH_A_TAIL,
            i2cm_pkg::PH_R_LOW:  begin w_scl = 1'b0; w_pull = 1'b0;      end
            i2cm_pkg::PH_A_HIGH,
            i2cm_pkg::PH_A_POLL,
            i2cm_pkg::PH_R_H1,
            i2cm_pkg::PH_R_H2:   begin w_scl = 1'b1; w_pull = 1'b0;      end
            i2cm_pkg::PH_K_SET,
            i2cm_pkg::PH_K_LOW:  begin w_scl = 1'b0; w_pull = w_ackpull; end
            i2cm_pkg::PH_K_HIGH: begin w_scl = 1'b1; w_pull = w_ackpull; end
            i2cm_pkg::PH_STO_A:  begin w_scl = 1'b0; w_pull = 1'b1;      end
            i2cm_pkg::PH_STO_B:  begin w_scl = 1'b1; w_pull = 1'b1;      end
            default:             begin w_scl = 1'b1; w_pull = 1'b0;      end
        endcase
    end

    // Result of this tick
    always_comb begin
        o_result.scl_level     = w_scl;
        o_result.sda_pull_low  = w_pull;
        o_result.read_valid    = w_rvalid;
        o_result.read_data     = w_rdata;
        o_result.read_last     = w_rlast;
        o_result.transfer_done = w_done;
        o_result.ack_error     = n_err;
        o_result.busy_res      = (n_phase != i2cm_pkg::PH_IDLE);
    end

endmodule

// ----- hw/rtl/i2c_master_register_access.sv -----
// A result passes from the input register through the tick logic into the
// result register. Throughput: one tick item per cycle while not stalled;
// a waiting result stalls the input only when the input register is full.
// Reset (i_rst_n low, synchronous): bus idle, counters and flags cleared,
// phase_ticks = 200, ack_poll_limit = 251; payload buffer holds no reset value.
module i2c_master_register_access (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  i2cm_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output i2cm_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [15:0]     i_cfg_data
);

    logic                        r_in_valid;
    i2cm_pkg::t_in               r_in_data;
    logic                        r_out_valid;
    i2cm_pkg::t_out              r_out_data;
    logic [15:0]                 r_phase_ticks;
    logic [9:0]                  r_ack_poll_limit;

    logic                        w_out_free;
    logic                        w_step;
    i2cm_pkg::t_out              w_result;
    logic [i2cm_pkg::SLOT_W-1:0] w_pay_raddr;
    logic [7:0]                  w_pay_rdata;

    // Pipeline flow control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks    <= i2cm_pkg::PHASE_TICKS_RST;
            r_ack_poll_limit <= i2cm_pkg::ACK_POLL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cm_pkg::CFG_PHASE_TICKS: r_phase_ticks    <= i_cfg_data;
                i2cm_pkg::CFG_ACK_POLL:    r_ack_poll_limit <= i_cfg_data[9:0];
                default:                   r_phase_ticks    <= r_phase_ticks;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Payload buffer, loaded by the load opcode in any bus phase
    i2cm_payload u_payload (
        .i_clk   (i_clk),
        .i_we    (w_step && (r_in_data.opcode == i2cm_pkg::OP_LOAD)),
        .i_waddr (r_in_data.payload_index),
        .i_wdata (r_in_data.payload_byte),
        .i_raddr (w_pay_raddr),
        .o_rdata (w_pay_rdata)
    );

    // Tick sequencer
    i2cm_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_step),
        .i_item           (r_in_data),
        .i_phase_ticks    (r_phase_ticks),
        .i_ack_poll_limit (r_ack_poll_limit),
        .i_pay_rdata      (w_pay_rdata),
        .o_pay_raddr      (w_pay_raddr),
        .o_result         (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
